>>> hdl/ssmd_pkg.sv
// ----------------------------------------------------------------------------
// ssmd_pkg
// Widths, pipeline sizing and register indexes of the signed scale unit.
// ----------------------------------------------------------------------------
package ssmd_pkg;

   localparam int DATA_W             = 64;
   localparam int CFG_W              = 32;
   localparam int HALF_W             = DATA_W / 2;
   localparam int PROD_W             = DATA_W + CFG_W;
   localparam int CSR_INDEX_W        = 8;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = PROD_W / DIV_BITS_PER_STAGE;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MULTIPLIER = 8'd0,
      CSR_DIVISOR    = 8'd1
   } csr_index_type;

   localparam logic [CFG_W-1:0] CFG_RESET = 32'd1;

endpackage

>>> hdl/signed_scale_mul_div_unit.sv
// The 96 restoring-division steps run two per stage over 48 stages.
// Throughput: one item per cycle while req_stall is low; the multiply, the
// product add and each division stage are one register stage each.
// Reset: synchronous, active high; clears all valid bits and the skid slot,
// and sets the multiplier and divisor registers to 1.
// ----------------------------------------------------------------------------
// signed_scale_mul_div_unit
// Scales a signed 64-bit value by multiplier / divisor, truncating toward zero
// and wrapping to 64 bits; a zero divisor gives zero and raises divide_error.
// ----------------------------------------------------------------------------
module signed_scale_mul_div_unit
   import ssmd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [DATA_W-1:0]      req_value_in,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DATA_W-1:0]      rsp_scaled_out,
   output logic                   rsp_divide_error,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   // ------------------------------------------------------------------
   // Configuration registers. Writes must arrive only while no item is
   // in flight; the block does not enforce it. Every stage reads them directly.
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] multiplier_ff;
   logic [CFG_W-1:0] divisor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         multiplier_ff <= CFG_RESET;
         divisor_ff    <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MULTIPLIER: begin
               multiplier_ff <= csr_data;
            end
            CSR_DIVISOR: begin
               divisor_ff <= csr_data;
            end
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Global advance. The skid slot at the output absorbs the one item
   // that may arrive while a result is held, so the pipeline stalls
   // only on a registered flag and req_stall never waits on rsp_stall
   // through logic.
   // ------------------------------------------------------------------
   logic advance;
   logic skid_valid_ff;
   logic req_accept;

   assign advance    = !skid_valid_ff;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Stage 1: set the sign aside and take the magnitude. The most
   // negative input becomes the unsigned value 2^63.
   // ------------------------------------------------------------------
   logic              mag_valid_ff;
   logic [DATA_W-1:0] mag_ff;
   logic              mag_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
      end else if (advance) begin
         mag_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_neg_ff <= req_value_in[DATA_W-1];
         mag_ff     <= req_value_in[DATA_W-1] ? (~req_value_in + 1'b1) : req_value_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: two 32x32 partial products, high and low half.
   // ------------------------------------------------------------------
   logic                prod_part_valid_ff;
   logic                prod_part_neg_ff;
   logic [2*CFG_W-1:0]  prod_hi_ff;
   logic [2*CFG_W-1:0]  prod_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_part_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_part_valid_ff <= mag_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_part_neg_ff <= mag_neg_ff;
         prod_hi_ff       <= mag_ff[DATA_W-1:HALF_W] * multiplier_ff;
         prod_lo_ff       <= mag_ff[HALF_W-1:0] * multiplier_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: join the partial products into the 96-bit dividend.
   // ------------------------------------------------------------------
   logic              prod_valid_ff;
   logic              prod_neg_ff;
   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= prod_part_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_neg_ff <= prod_part_neg_ff;
         prod_ff     <= {prod_hi_ff, {HALF_W{1'b0}}}
                      + {{(PROD_W-2*CFG_W){1'b0}}, prod_lo_ff};
      end
   end

   // ------------------------------------------------------------------
   // Stages 4..51: restoring division, dividend bits shift out of the
   // top of the work word into the remainder while quotient bits shift
   // in at the bottom. After all steps the work word is the quotient.
   // ------------------------------------------------------------------
   logic [DIV_STAGES-1:0] div_valid_ff;
   logic [DIV_STAGES-1:0] div_neg_ff;
   logic [CFG_W-1:0]      div_rem_ff  [DIV_STAGES];
   logic [PROD_W-1:0]     div_work_ff [DIV_STAGES];
   logic [CFG_W-1:0]      div_rem_in  [DIV_STAGES];
   logic [PROD_W-1:0]     div_work_in [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      always_comb begin
         logic [CFG_W:0]    trial;
         logic [CFG_W-1:0]  rem;
         logic [PROD_W-1:0] work;
         if (j == 0) begin
            rem  = '0;
            work = prod_ff;
         end else begin
            rem  = div_rem_ff[j-1];
            work = div_work_ff[j-1];
         end
         for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
            trial = {rem, work[PROD_W-1]};
            work  = {work[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_ff}) begin
               rem     = CFG_W'(trial - {1'b0, divisor_ff});
               work[0] = 1'b1;
            end else begin
               rem = trial[CFG_W-1:0];
            end
         end
         div_rem_in[j]  = rem;
         div_work_in[j] = work;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= '0;
      end else if (advance) begin
         div_valid_ff <= {div_valid_ff[DIV_STAGES-2:0], prod_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_neg_ff <= {div_neg_ff[DIV_STAGES-2:0], prod_neg_ff};
         for (int j = 0; j < DIV_STAGES; j++) begin
            div_rem_ff[j]  <= div_rem_in[j];
            div_work_ff[j] <= div_work_in[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 52: keep the low 64 quotient bits, restore the sign, force
   // zero on a zero divisor.
   // ------------------------------------------------------------------
   logic              fin_valid_ff;
   logic [DATA_W-1:0] fin_scaled_ff;
   logic              fin_error_ff;
   logic [DATA_W-1:0] quot;
   logic              div_zero;

   assign quot     = div_work_ff[DIV_STAGES-1][DATA_W-1:0];
   assign div_zero = (divisor_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_valid_ff <= div_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin_error_ff <= div_zero;
         if (div_zero) begin
            fin_scaled_ff <= '0;
         end else if (div_neg_ff[DIV_STAGES-1]) begin
            fin_scaled_ff <= ~quot + 1'b1;
         end else begin
            fin_scaled_ff <= quot;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 53: output register plus one skid slot. An arriving item
   // goes to the output register when it is free or being taken, else
   // into the skid slot; the skid slot drains first.
   // ------------------------------------------------------------------
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_scaled_ff;
   logic              rsp_error_ff;
   logic [DATA_W-1:0] skid_scaled_ff;
   logic              skid_error_ff;
   logic              rsp_take;
   logic              arrive;
   logic              rsp_load;
   logic              skid_load;

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign arrive    = advance && fin_valid_ff;
   assign rsp_load  = arrive && (!rsp_valid_ff || rsp_take);
   assign skid_load = arrive && rsp_valid_ff && !rsp_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (skid_load) begin
         skid_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && rsp_take) begin
         rsp_scaled_ff <= skid_scaled_ff;
         rsp_error_ff  <= skid_error_ff;
      end else if (rsp_load) begin
         rsp_scaled_ff <= fin_scaled_ff;
         rsp_error_ff  <= fin_error_ff;
      end
      if (skid_load) begin
         skid_scaled_ff <= fin_scaled_ff;
         skid_error_ff  <= fin_error_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scaled_out   = rsp_scaled_ff;
   assign rsp_divide_error = rsp_error_ff;

endmodule

>>> hdl/ssmd_checker.sv
// ----------------------------------------------------------------------------
// ssmd_assertions
// Port-level checks of the signed scale unit, bound to the top level.
// ----------------------------------------------------------------------------
module ssmd_assertions
   import ssmd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [DATA_W-1:0]      req_value_in,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [DATA_W-1:0]      rsp_scaled_out,
   input logic                   rsp_divide_error
);

   // reset empties the pipeline and the skid slot
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // a stalled request item stays offered with its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_value_in))
      else $error("stalled request item changed");

   // a zero divisor always comes with a zero result
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_scaled_out == '0)
      else $error("divide error with nonzero result");

   // a held result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   // a held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_scaled_out) && $stable(rsp_divide_error))
      else $error("stalled result changed");

endmodule

bind signed_scale_mul_div_unit ssmd_assertions u_ssmd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_value_in     (req_value_in),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_scaled_out   (rsp_scaled_out),
   .rsp_divide_error (rsp_divide_error)
);
